FILE: hw/rtl/q8bd_pkg.sv
// shared types and constants for the q8 block dequantizer
`timescale 1ns / 1ps
`default_nettype none
package q8bd_pkg;

  localparam int unsigned LANES     = 8;
  localparam int unsigned W_WIDTH   = 8;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned SINGLE_W  = 32;
  localparam int unsigned SIG_W     = 11;
  localparam int unsigned HEXP_W    = 5;
  localparam int unsigned PROD_W    = W_WIDTH + SIG_W - 1;
  localparam int unsigned POS_W     = $clog2(PROD_W);

  // single exponent = lead position + half exponent + (127 - 15 - 10)
  localparam logic [7:0]  EXP_OFFSET = 8'd102;
  localparam logic [4:0]  HEXP_MAX   = 5'h1F;
  localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS   = 32'h7F80_0000;

  // decoded half-precision scale
  typedef struct packed {
    logic              sign;
    logic [HEXP_W-1:0] exp_eff;
    logic [SIG_W-1:0]  sig;
    logic              is_inf;
    logic              is_nan;
  } scale_t;

  typedef logic [SINGLE_W-1:0] value_t;

endpackage
`default_nettype wire

FILE: hw/rtl/q8bd_in_if.sv
// input channel: scale word, eight weights and last-group flag
`timescale 1ns / 1ps
`default_nettype none
interface q8bd_in_if;
  logic              valid;
  logic              ready;
  logic [15:0]       scale_half;
  logic signed [7:0] weight_0;
  logic signed [7:0] weight_1;
  logic signed [7:0] weight_2;
  logic signed [7:0] weight_3;
  logic signed [7:0] weight_4;
  logic signed [7:0] weight_5;
  logic signed [7:0] weight_6;
  logic signed [7:0] weight_7;
  logic              last_group;

  modport source (output valid, scale_half, weight_0, weight_1, weight_2, weight_3,
                  weight_4, weight_5, weight_6, weight_7, last_group, input ready);
  modport sink   (input valid, scale_half, weight_0, weight_1, weight_2, weight_3,
                  weight_4, weight_5, weight_6, weight_7, last_group, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/q8bd_out_if.sv
// output channel: eight single-precision values and last flag
`timescale 1ns / 1ps
`default_nettype none
interface q8bd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_0;
  logic [31:0] value_1;
  logic [31:0] value_2;
  logic [31:0] value_3;
  logic [31:0] value_4;
  logic [31:0] value_5;
  logic [31:0] value_6;
  logic [31:0] value_7;
  logic        last_out;

  modport source (output valid, value_0, value_1, value_2, value_3, value_4, value_5,
                  value_6, value_7, last_out, input ready);
  modport sink   (input valid, value_0, value_1, value_2, value_3, value_4, value_5,
                  value_6, value_7, last_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/q8_block_dequantizer.sv
// top level: scale decode, eight lanes, result register and output register
//
// Q8_0 group dequantizer. Each input beat carries one group of eight signed
// 8-bit weights with the half-precision scale of their block; each output
// beat carries the eight exact single-precision products plus the copied
// last flag. NaN results come out as 0x7FC00000. A beat passes the lane
// result register, then the output register; one beat is taken every cycle
// while the output side keeps taking beats. These two registers form a
// two-deep pipeline, so a new beat is accepted while a finished one waits.
// No clearing pass or configuration.
`timescale 1ns / 1ps
`default_nettype none
module q8_block_dequantizer
  import q8bd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  q8bd_in_if.sink     in_i,
  q8bd_out_if.source  out_o
);

  scale_t                  scale;
  logic [W_WIDTH-1:0]      weights [LANES];
  value_t                  lane_val [LANES];
  value_t                  s1_val_q [LANES];
  value_t                  out_val_q [LANES];
  logic                    s1_last_q, out_last_q;
  logic                    s1_valid_q, s1_valid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    s1_move, in_take;

  assign weights[0] = in_i.weight_0;
  assign weights[1] = in_i.weight_1;
  assign weights[2] = in_i.weight_2;
  assign weights[3] = in_i.weight_3;
  assign weights[4] = in_i.weight_4;
  assign weights[5] = in_i.weight_5;
  assign weights[6] = in_i.weight_6;
  assign weights[7] = in_i.weight_7;

  q8bd_scale_dec u_scale (
    .scale_half_i (in_i.scale_half),
    .scale_o      (scale)
  );

  // lanes side by side
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q8bd_lane u_lane (
      .weight_i (weights[g]),
      .scale_i  (scale),
      .value_o  (lane_val[g])
    );
  end

  // handshake of the two stages
  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_move;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
    out_valid_d = s1_move ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, merged into one output beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_val_q  <= lane_val;
      s1_last_q <= in_i.last_group;
    end
    if (s1_move) begin
      out_val_q  <= s1_val_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.value_0  = out_val_q[0];
  assign out_o.value_1  = out_val_q[1];
  assign out_o.value_2  = out_val_q[2];
  assign out_o.value_3  = out_val_q[3];
  assign out_o.value_4  = out_val_q[4];
  assign out_o.value_5  = out_val_q[5];
  assign out_o.value_6  = out_val_q[6];
  assign out_o.value_7  = out_val_q[7];
  assign out_o.last_out = out_last_q;

endmodule
`default_nettype wire

FILE: hw/rtl/q8bd_scale_dec.sv
// half-precision scale decode shared by all lanes
`timescale 1ns / 1ps
`default_nettype none
module q8bd_scale_dec
  import q8bd_pkg::*;
(
  input  logic [HALF_W-1:0] scale_half_i,
  output scale_t            scale_o
);

  logic [HEXP_W-1:0] hexp;
  logic [SIG_W-2:0]  man;

  assign hexp = scale_half_i[HALF_W-2 -: HEXP_W];
  assign man  = scale_half_i[SIG_W-2:0];

  // subnormals share the exponent of the smallest normal, no hidden bit
  always_comb begin
    scale_o.sign    = scale_half_i[HALF_W-1];
    scale_o.exp_eff = (hexp == '0) ? HEXP_W'(1) : hexp;
    scale_o.sig     = {(hexp != '0), man};
    scale_o.is_inf  = (hexp == HEXP_MAX) && (man == '0);
    scale_o.is_nan  = (hexp == HEXP_MAX) && (man != '0);
  end

endmodule
`default_nettype wire

FILE: hw/rtl/q8bd_lane.sv
// one lane: exact weight times scale, packed as single precision
`timescale 1ns / 1ps
`default_nettype none
module q8bd_lane
  import q8bd_pkg::*;
(
  input  logic [W_WIDTH-1:0] weight_i,
  input  scale_t             scale_i,
  output value_t             value_o
);

  logic               wneg;
  logic               sign;
  logic [W_WIDTH-1:0] mag;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  norm;
  logic [POS_W-1:0]   lead;
  logic [7:0]         exp_s;

  assign wneg = weight_i[W_WIDTH-1];
  assign sign = wneg ^ scale_i.sign;
  assign mag  = wneg ? W_WIDTH'(-weight_i) : weight_i;
  assign prod = PROD_W'(mag) * PROD_W'(scale_i.sig);

  // leading one position of the product
  always_comb begin
    lead = '0;
    for (int i = 0; i < PROD_W; i++) begin
      if (prod[i]) lead = POS_W'(i);
    end
  end

  assign norm  = prod << (POS_W'(PROD_W - 1) - lead);
  assign exp_s = 8'(lead) + 8'(scale_i.exp_eff) + EXP_OFFSET;

  // special cases first, then the normalized product
  always_comb begin
    if (scale_i.is_nan) begin
      value_o = CANON_NAN;
    end else if (scale_i.is_inf) begin
      value_o = (mag == '0) ? CANON_NAN : (INF_BITS | {sign, 31'b0});
    end else if (prod == '0) begin
      value_o = {sign, 31'b0};
    end else begin
      // fraction bits below the product are always zero
      value_o = {sign, exp_s, norm[PROD_W-2:0], {(SINGLE_W - PROD_W - 8){1'b0}}};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/q8bd_checker.sv
// port checker for the q8 block dequantizer and its bind
`timescale 1ns / 1ps
`default_nettype none
module q8bd_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [31:0] value_0_i,
  input wire [31:0] value_7_i
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(value_0_i))
    else $error("output beat dropped or changed while stalled");

  // every NaN on lanes 0 and 7 is the canonical quiet NaN
  a_nan_0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && value_0_i[30:23] == 8'hFF && value_0_i[22:0] != 23'd0
    |-> value_0_i == 32'h7FC0_0000)
    else $error("non canonical nan on lane 0");

  a_nan_7: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && value_7_i[30:23] == 8'hFF && value_7_i[22:0] != 23'd0
    |-> value_7_i == 32'h7FC0_0000)
    else $error("non canonical nan on lane 7");

  // lane 0 products are never subnormal
  a_no_subnormal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && value_0_i[30:23] == 8'h00 |-> value_0_i[22:0] == 23'd0)
    else $error("subnormal product on lane 0");

endmodule

bind q8_block_dequantizer q8bd_checker u_q8bd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .value_0_i   (out_o.value_0),
  .value_7_i   (out_o.value_7)
);
`default_nettype wire
